[sv/clipped_line_rasterizer_macros.svh]
// Assertion helpers shared by the rasteriser RTL.
`ifndef CLIPPED_LINE_RASTERIZER_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define CLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasteriser assertion failed");

// Next-cycle implication, disabled while in reset.
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasteriser assertion failed");

`else

`define CLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/clr_pkg.sv]
`default_nettype none

package clr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int MAX_DIM     = 32;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W);
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int EPS_W       = DIM_W + 3;
    localparam int MAX_PIX     = 2 * MAX_DIM - 1;
    localparam int CNT_W       = $clog2(2 * MAX_DIM);
    localparam int PIX_W       = 5;
    localparam int COLOR_W     = 32;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CLIP_PASSES = 4;
    localparam int PASS_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_BOTTOM = 4'b0100;
    localparam logic [3:0] OC_TOP    = 4'b1000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t               start_x;
        coord_t               start_y;
        coord_t               end_x;
        coord_t               end_y;
        logic [COLOR_W-1:0]   line_color;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_x;
        logic [PIX_W-1:0]     pixel_y;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 last_pixel;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic update;
        logic setup;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_canvas;
        logic trivial_out;
        logic den_zero;
        logic div_last;
        logic out_free;
        logic pix_last;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TEST = 5'b00010,
        S_DIV  = 5'b00100,
        S_UPD  = 5'b01000,
        S_DRAW = 5'b10000
    } state_t;

    function automatic logic [3:0] region(coord_t x, coord_t y,
                                          logic [DIM_W-1:0] xmax,
                                          logic [DIM_W-1:0] ymax);
        coord_t     xm;
        coord_t     ym;
        logic [3:0] c;
        xm = signed'(COORD_BITS'(xmax));
        ym = signed'(COORD_BITS'(ymax));
        c  = 4'b0000;
        if (x < 0) c = c | OC_LEFT;
        else if (x > xm) c = c | OC_RIGHT;
        if (y < 0) c = c | OC_BOTTOM;
        else if (y > ym) c = c | OC_TOP;
        return c;
    endfunction

    // Clamp a dimension register to 1..MAX_DIM and return the last index.
    function automatic logic [DIM_W-1:0] last_index(logic [CFG_W-1:0] dim);
        logic [CFG_W-1:0] eff;
        if (dim == '0) eff = CFG_W'(1);
        else if (dim > CFG_W'(MAX_DIM)) eff = CFG_W'(MAX_DIM);
        else eff = dim;
        return DIM_W'(eff - CFG_W'(1));
    endfunction

endpackage

`default_nettype wire

[sv/clr_control.sv]
`default_nettype none

`include "clipped_line_rasterizer_macros.svh"

module clr_control
    import clr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_stat_t   stat,
    output ctrl_cmd_t       cmd
);

    state_t            state_reg, state_next;
    logic [PASS_W-1:0] pass_reg, pass_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    pass_next  = '0;
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                priority if (stat.in_canvas) begin
                    cmd.setup  = 1'b1;
                    state_next = S_DRAW;
                end else if (stat.trivial_out || stat.den_zero
                             || pass_reg == PASS_W'(CLIP_PASSES)) begin
                    // drop the segment
                    state_next = S_IDLE;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = S_UPD;
            end
            S_UPD: begin
                cmd.update = 1'b1;
                pass_next  = pass_reg + PASS_W'(1);
                state_next = S_TEST;
            end
            S_DRAW: begin
                cmd.emit = stat.out_free;
                if (stat.out_free && stat.pix_last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    `CLR_ASSERT_IMPLY(a_pass_bound, aclk, aresetn, 1'b1, pass_reg <= PASS_W'(CLIP_PASSES))
    `CLR_ASSERT_IMPLY(a_draw_in_canvas, aclk, aresetn, state_reg == S_DRAW, stat.in_canvas)
    `CLR_ASSERT_NEXT(a_div_to_upd, aclk, aresetn,
        state_reg == S_DIV && stat.div_last, state_reg == S_UPD)

endmodule

`default_nettype wire

[sv/clr_datapath.sv]
`default_nettype none

`include "clipped_line_rasterizer_macros.svh"

module clr_datapath
    import clr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire in_word_t             s_data,
    output out_word_t                 m_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire ctrl_cmd_t            cmd,
    output dp_stat_t                  stat
);

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] xmax, ymax;

    coord_t ax_reg, ay_reg, bx_reg, by_reg;
    logic [COLOR_W-1:0] color_reg;

    // clip intersection
    logic [3:0]              ca, cb, csel;
    logic                    vert;
    coord_t                  edge_c;
    logic signed [DIFF_W-1:0] den, fa, fb;
    logic signed [PROD_W-1:0] prod;
    logic                    side_a_reg, vert_reg, neg_reg;
    coord_t                  edge_reg, base_reg;
    logic [DIFF_W-1:0]       dvs_reg;
    logic [PROD_W-1:0]       dvd_reg;
    logic [DIFF_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [DIFF_W:0]         trial;
    logic                    qbit;
    logic signed [DIFF_W-1:0] qs, newc;

    // line walk
    coord_t                  lo_x, lo_y, hi_x, hi_y;
    logic [DIM_W-1:0]        dx_reg, dy_reg, wx_reg, wy_reg, ex_reg, ey_reg;
    logic                    down_reg, vline_reg;
    logic signed [EPS_W-1:0] eps_reg, two_dx, two_dy, eps_sub;
    logic [CNT_W-1:0]        n_reg;
    logic [DIM_W-1:0]        py, wy_step;
    logic                    pix_last;
    logic                    col_end;

    out_word_t m_data_reg;
    logic      m_valid_reg;

    assign xmax = last_index(width_reg);
    assign ymax = last_index(height_reg);
    assign ca   = region(ax_reg, ay_reg, xmax, ymax);
    assign cb   = region(bx_reg, by_reg, xmax, ymax);
    assign csel = (ca != 4'b0000) ? ca : cb;
    assign vert = (csel & (OC_TOP | OC_BOTTOM)) != 4'b0000;

    always_comb begin
        if (vert) begin
            edge_c = ((csel & OC_TOP) != 4'b0000) ? signed'(COORD_BITS'(ymax)) : '0;
            den    = DIFF_W'(by_reg) - DIFF_W'(ay_reg);
            fa     = DIFF_W'(bx_reg) - DIFF_W'(ax_reg);
            fb     = DIFF_W'(edge_c) - DIFF_W'(ay_reg);
        end else begin
            edge_c = ((csel & OC_RIGHT) != 4'b0000) ? signed'(COORD_BITS'(xmax)) : '0;
            den    = DIFF_W'(bx_reg) - DIFF_W'(ax_reg);
            fa     = DIFF_W'(by_reg) - DIFF_W'(ay_reg);
            fb     = DIFF_W'(edge_c) - DIFF_W'(ax_reg);
        end
        prod = fa * fb;
    end

    assign stat.in_canvas   = (ca | cb) == 4'b0000;
    assign stat.trivial_out = (ca & cb) != 4'b0000;
    assign stat.den_zero    = (den == '0);
    assign stat.div_last    = (div_cnt_reg == DIV_CNT_W'(PROD_W - 1));

    // restoring divide, one quotient bit a cycle
    assign trial = {rem_reg, dvd_reg[PROD_W-1]} - {1'b0, dvs_reg};
    assign qbit  = !trial[DIFF_W];
    assign qs    = neg_reg ? -signed'(dvd_reg[DIFF_W-1:0]) : signed'(dvd_reg[DIFF_W-1:0]);
    assign newc  = DIFF_W'(base_reg) + qs;

    always_comb begin
        if (bx_reg < ax_reg) begin
            lo_x = bx_reg; lo_y = by_reg; hi_x = ax_reg; hi_y = ay_reg;
        end else begin
            lo_x = ax_reg; lo_y = ay_reg; hi_x = bx_reg; hi_y = by_reg;
        end
    end

    assign two_dx  = signed'(EPS_W'({dx_reg, 1'b0}));
    assign two_dy  = signed'(EPS_W'({dy_reg, 1'b0}));
    assign eps_sub = eps_reg - two_dx;
    assign wy_step = down_reg ? wy_reg - DIM_W'(1) : wy_reg + DIM_W'(1);

    always_comb begin
        col_end = 1'b1;
        if (vline_reg) begin
            py       = wy_reg;
            pix_last = (wy_reg == ey_reg);
        end else if (!eps_reg[EPS_W-1]) begin
            py       = wy_step;
            col_end  = eps_sub[EPS_W-1];
            pix_last = col_end && (wx_reg == ex_reg);
        end else begin
            py       = wy_reg;
            pix_last = (wx_reg == ex_reg);
        end
        pix_last = pix_last || (n_reg == CNT_W'(MAX_PIX - 1));
    end

    assign stat.pix_last = pix_last;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(MAX_DIM);
            height_reg <= CFG_W'(MAX_DIM);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:  width_reg  <= cfg_wdata;
                REG_CANVAS_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg    <= s_data.start_x;
            ay_reg    <= s_data.start_y;
            bx_reg    <= s_data.end_x;
            by_reg    <= s_data.end_y;
            color_reg <= s_data.line_color;
        end else if (cmd.update) begin
            if (side_a_reg) begin
                ax_reg <= vert_reg ? newc[COORD_BITS-1:0] : edge_reg;
                ay_reg <= vert_reg ? edge_reg : newc[COORD_BITS-1:0];
            end else begin
                bx_reg <= vert_reg ? newc[COORD_BITS-1:0] : edge_reg;
                by_reg <= vert_reg ? edge_reg : newc[COORD_BITS-1:0];
            end
        end
        if (cmd.mul) begin
            side_a_reg  <= (ca != 4'b0000);
            vert_reg    <= vert;
            edge_reg    <= edge_c;
            base_reg    <= vert ? ax_reg : ay_reg;
            neg_reg     <= prod[PROD_W-1] ^ den[DIFF_W-1];
            dvd_reg     <= prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
            dvs_reg     <= den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= qbit ? trial[DIFF_W-1:0] : {rem_reg[DIFF_W-2:0], dvd_reg[PROD_W-1]};
            dvd_reg     <= {dvd_reg[PROD_W-2:0], qbit};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.setup) begin
            wx_reg    <= DIM_W'(lo_x);
            wy_reg    <= DIM_W'(lo_y);
            ex_reg    <= DIM_W'(hi_x);
            ey_reg    <= DIM_W'(hi_y);
            dx_reg    <= DIM_W'(hi_x - lo_x);
            dy_reg    <= (hi_y > lo_y) ? DIM_W'(hi_y - lo_y) : DIM_W'(lo_y - hi_y);
            down_reg  <= !(hi_y > lo_y);
            vline_reg <= (hi_x == lo_x);
            eps_reg   <= -signed'(EPS_W'(unsigned'(DIM_W'(hi_x - lo_x))));
            n_reg     <= '0;
        end else if (cmd.emit) begin
            n_reg <= n_reg + CNT_W'(1);
            if (vline_reg) begin
                wy_reg <= wy_step;
            end else if (!eps_reg[EPS_W-1]) begin
                wy_reg <= wy_step;
                if (col_end) begin
                    eps_reg <= eps_sub + two_dy;
                    wx_reg  <= wx_reg + DIM_W'(1);
                end else begin
                    eps_reg <= eps_sub;
                end
            end else begin
                eps_reg <= eps_reg + two_dy;
                wx_reg  <= wx_reg + DIM_W'(1);
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.pixel_x     <= PIX_W'(wx_reg);
            m_data_reg.pixel_y     <= PIX_W'(py);
            m_data_reg.pixel_color <= color_reg;
            m_data_reg.last_pixel  <= pix_last;
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

    `CLR_ASSERT_IMPLY(a_emit_free, aclk, aresetn, cmd.emit, !m_valid_reg || m_ready)

endmodule

`default_nettype wire

[sv/clipped_line_rasterizer.sv]
// Each segment is loaded, then each clip pass multiplies, runs the divide and updates one endpoint.
// Up to four passes, then for a kept segment one pixel word per cycle while the output is free, at most 63.
// One segment at a time: a new one is taken only in the idle state;
// the iterative clip divider and the pixel walk set how long each segment takes.
// Reset (aresetn low, synchronous) empties the output and sets both canvas sizes to 32.
`default_nettype none

module clipped_line_rasterizer
    import clr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_word_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_word_t                 m_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    clr_control u_control (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    clr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
